@@ rtl/assert_macros.svh @@
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LIS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LIS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lis_pkg.sv @@
package lis_pkg;

    localparam int VALUE_W   = 32;
    localparam int LEN_OUT_W = 11;
    // Level index width; covers up to 32 levels of the search chain.
    localparam int LVL_W     = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    // Token handed from one cell to the next.
    typedef struct packed {
        logic                       valid;
        logic signed [VALUE_W-1:0]  value;
        logic        [LVL_W-1:0]    tgt;    // deepest level that turned left
    } link_t;

    // Write-back command broadcast to every cell.
    typedef struct packed {
        logic                       en;
        logic        [LVL_W-1:0]    level;
        logic signed [VALUE_W-1:0]  value;
    } wb_cmd_t;

endpackage

@@ rtl/lis_length_patience_unit.sv @@
// Longest strictly increasing subsequence length, patience-sorting form.
// Each transfer on s_ brings one signed 32-bit value; each item yields one
// transfer on m_ with the length so far, an echo of is_last, and a flag that
// is set once a value was dropped because the tail list was full. The tails
// are kept sorted in a complete binary search tree laid out by level: a row
// of L = clog2(MAX_LEN+1) identical cells, cell k owning the 2^k nodes of
// level k in a small RAM of its own (2^L - 1 entries in total). An item
// enters the row at cell 0 and moves one cell per cycle; each cell compares
// it with one node and hands the chosen path bit to the next cell, which
// uses it as its read address. At the end of the row the path is the number
// of tails below the value, i.e. the replace or append position, and the
// deepest left turn names the cell that holds that position. The path is
// latched, and the update step then writes the value back and loads the result
// register, once that register is free. With m_ready high the result transfers
// on the next edge. One item is in flight at a time, and the next is accepted
// as soon as the result is loaded, even while it still waits on m_ready; that
// item then holds before write-back until the result register is free. After
// a last item the length and flag are cleared; tails are left in place and
// nodes at or past the current length are ignored, so the RAMs need no
// clearing after reset.
module lis_length_patience_unit
    import lis_pkg::*;
#(
    parameter int MAX_LEN = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [VALUE_W-1:0]   s_value,
    input  logic                        s_is_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [LEN_OUT_W-1:0]        m_lis_length,
    output logic                        m_end_of_sequence,
    output logic                        m_overflow
);

    // number of tree levels; also wide enough for a length of MAX_LEN
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam logic [LW-1:0] MAX_L = (LW)'(MAX_LEN);

    state_t                      state_reg, state_next;
    logic        [LW-1:0]        len_reg, len_next;
    logic                        ovf_reg, ovf_next;
    logic                        last_reg;
    logic        [LW-1:0]        pos_reg;
    logic        [LVL_W-1:0]     tgt_reg;
    logic signed [VALUE_W-1:0]   val_reg;
    logic                        m_valid_reg, m_valid_next;
    logic        [LEN_OUT_W-1:0] m_len_reg, m_len_next;
    logic                        m_eos_reg, m_eos_next;
    logic                        m_ovf_reg, m_ovf_next;
    logic                        load_out;
    logic                        capture;
    logic                        s_xfer;
    logic                        at_end;
    logic        [LW-1:0]        len_upd;
    logic                        ovf_upd;
    wb_cmd_t                     wb;

    link_t                       lnk    [LW+1];
    logic        [LW-1:0]        prefix [LW+1];

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;

    // feed the head of the row
    assign lnk[0].valid = s_xfer;
    assign lnk[0].value = s_value;
    assign lnk[0].tgt   = '0;
    assign prefix[0]    = '0;

    for (genvar k = 0; k < LW; k++) begin : g_cell
        lis_cell #(
            .LEVEL (k),
            .LW    (LW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .in_lnk     (lnk[k]),
            .in_prefix  (prefix[k]),
            .len        (len_reg),
            .wb         (wb),
            .out_lnk    (lnk[k+1]),
            .out_prefix (prefix[k+1])
        );
    end

    assign capture = (state_reg == ST_SEARCH) && lnk[LW].valid;

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_len_next   = m_len_reg;
        m_eos_next   = m_eos_reg;
        m_ovf_next   = m_ovf_reg;
        load_out     = 1'b0;

        // position equal to the length means append; at capacity, drop it
        at_end  = (pos_reg == len_reg);
        len_upd = (at_end && (len_reg != MAX_L)) ? len_reg + 1'b1 : len_reg;
        ovf_upd = ovf_reg || (at_end && (len_reg == MAX_L));

        wb.en    = 1'b0;
        wb.level = tgt_reg;
        wb.value = val_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (lnk[LW].valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    wb.en        = (pos_reg != MAX_L);
                    m_valid_next = 1'b1;
                    m_len_next   = LEN_OUT_W'(len_upd);
                    m_eos_next   = last_reg;
                    m_ovf_next   = ovf_upd;
                    len_next     = last_reg ? '0 : len_upd;
                    ovf_next     = last_reg ? 1'b0 : ovf_upd;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        if (s_xfer) begin
            last_reg <= s_is_last;
        end
        if (capture) begin
            pos_reg <= prefix[LW];
            tgt_reg <= lnk[LW].tgt;
            val_reg <= lnk[LW].value;
        end
        if (load_out) begin
            m_len_reg <= m_len_next;
            m_eos_reg <= m_eos_next;
            m_ovf_reg <= m_ovf_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_lis_length      = m_len_reg;
    assign m_end_of_sequence = m_eos_reg;
    assign m_overflow        = m_ovf_reg;

endmodule

@@ rtl/lis_ram.sv @@
module lis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/lis_cell.sv @@
// One level of the search tree: holds the tails of that level in its own RAM,
// compares the passing value against one node, and steers the path.
module lis_cell
    import lis_pkg::*;
#(
    parameter int LEVEL = 0,
    parameter int LW    = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  link_t         in_lnk,
    input  logic [LW-1:0] in_prefix,
    input  logic [LW-1:0] len,
    input  wb_cmd_t       wb,
    output link_t         out_lnk,
    output logic [LW-1:0] out_prefix
);

    localparam int DEPTH = 1 << LEVEL;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SHIFT = LW - LEVEL;
    localparam logic [LW-1:0] LOW_ONES = (LW)'((1 << (SHIFT - 1)) - 1);

    logic                        valid_reg;
    logic signed [VALUE_W-1:0]   value_reg;
    logic        [LVL_W-1:0]     tgt_reg;
    logic        [LW-1:0]        prefix_reg;
    logic        [VALUE_W-1:0]   rd_data;
    logic        [LW-1:0]        node_idx;
    logic                        node_ok;
    logic                        less;
    logic                        we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_lnk.valid;
        end
        if (in_lnk.valid) begin
            value_reg  <= in_lnk.value;
            tgt_reg    <= in_lnk.tgt;
            prefix_reg <= in_prefix;
        end
    end

    // prefix_reg keeps the node address until the next item, so write-back
    // hits the node this item visited.
    assign we = wb.en && (wb.level == LVL_W'(LEVEL));

    lis_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (aclk),
        .we      (we),
        .wr_addr (prefix_reg[AW-1:0]),
        .wr_data (wb.value),
        .rd_en   (in_lnk.valid),
        .rd_addr (in_prefix[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        // sorted position of this node; positions at or past len count as +inf
        node_idx = (prefix_reg << SHIFT) | LOW_ONES;
        node_ok  = node_idx < len;
        less     = node_ok && ($signed(rd_data) < value_reg);

        out_lnk.valid = valid_reg;
        out_lnk.value = value_reg;
        out_lnk.tgt   = less ? tgt_reg : LVL_W'(LEVEL);
        out_prefix    = (LW)'({prefix_reg, less});
    end

endmodule

@@ rtl/lis_checker.sv @@
`include "assert_macros.svh"

module lis_checker
    import lis_pkg::*;
#(
    parameter int MAX_LEN = 1024
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [LEN_OUT_W-1:0]        m_lis_length,
    input logic                        m_end_of_sequence,
    input logic                        m_overflow
);

    // one item in flight: input closes right after a transfer
    `LIS_ASSERT_NEXT(a_busy_after_in, aclk, aresetn,
        s_valid && s_ready, !s_ready, "input ready after transfer")

    // a fresh result reopens the input in the same edge
    `LIS_ASSERT_NOW(a_ready_with_result, aclk, aresetn,
        $rose(m_valid), s_ready, "result without ready input")

    // a fresh result only follows a busy period
    `LIS_ASSERT_NOW(a_result_after_work, aclk, aresetn,
        $rose(m_valid), $past(!s_ready), "result from idle")

    // a dropped append implies the length sits at capacity
    `LIS_ASSERT_NOW(a_ovf_at_cap, aclk, aresetn,
        m_valid && m_overflow, m_lis_length == LEN_OUT_W'(MAX_LEN), "overflow below capacity")

    // a stalled result holds
    `LIS_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready,
        m_valid && $stable(m_lis_length) && $stable(m_end_of_sequence) && $stable(m_overflow),
        "stalled result changed")

endmodule

bind lis_length_patience_unit lis_checker #(.MAX_LEN(MAX_LEN)) u_lis_checker (.*);
